@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define AST_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// expression must never be true outside reset
`define AST_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

@@ rtl/core/fwr_pkg.sv @@
// ----------------------------------------------------------------------------
// fwr_pkg
// types, constants and crc function for the framed word receiver
// ----------------------------------------------------------------------------
`default_nettype none

package fwr_pkg;

    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REQ_FRAME   = 2'd0,
        REQ_START   = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_UNUSED  = 2'd3
    } t_req;

    localparam logic       KIND_DATA = 1'b0;
    localparam logic       KIND_RESP = 1'b1;

    localparam logic [3:0] WORDS_DATA = 4'd12;
    localparam logic [3:0] WORDS_RESP = 4'd4;

    localparam logic [3:0] HDR_DATA_LEAD = 4'hc;
    localparam logic [3:0] HDR_DATA_BODY = 4'h8;
    localparam logic [3:0] HDR_DATA_TAIL = 4'ha;
    localparam logic [3:0] HDR_RESP_LEAD = 4'hd;
    localparam logic [3:0] HDR_RESP_BODY = 4'h9;
    localparam logic [3:0] HDR_RESP_TAIL = 4'hb;

    localparam logic [5:0]  PAYLOAD_MASK = 6'h3f;
    localparam logic [15:0] CRC_INIT     = 16'hffff;

    localparam logic [15:0] CRC_TAPS [16] = '{
        16'h1911, 16'h3222, 16'h6444, 16'hc888,
        16'h9110, 16'h3b31, 16'h7662, 16'hecc4,
        16'hd988, 16'hb310, 16'h6620, 16'hcc40,
        16'h8191, 16'h0322, 16'h0644, 16'h0c88
    };

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [7:0] byte_third;
    } t_in;

    typedef struct packed {
        logic [15:0] word;
        logic [3:0]  word_index;
        logic        word_valid;
        logic        frame_dropped;
        logic        message_complete;
        logic        crc_ok;
        logic        damaged;
    } t_out;

    // word-parallel crc-16 ccitt update
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [15:0] w);
        logic [15:0] x;
        logic [15:0] r;
        x = crc ^ w;
        for (int i = 0; i < 16; i++) begin
            r[i] = ^(x & CRC_TAPS[i]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/framed_word_receiver_crc_check_top.sv @@
// path: an accepted item sits in the input register, its result in the result register,
// so an output transfer follows its input transfer through both registers
// throughput: one item per cycle when not stalled, set by the single registered crc update
// a stalled result lets one more item into the input register, then the input stalls
// reset (synchronous, active low) clears word count, damage marks, kind and valids
// crc register returns to ffff on reset
// ----------------------------------------------------------------------------
// framed_word_receiver_crc_check_top
// three-byte frame deframer with crc-16 check, apb configured
// ----------------------------------------------------------------------------
`default_nettype none

module framed_word_receiver_crc_check_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire fwr_pkg::t_in                    i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output fwr_pkg::t_out                        o_out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fwr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [fwr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [fwr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import fwr_pkg::*;

    logic r_in_valid;
    t_in  r_in;
    logic n_in_valid;
    logic proc;
    logic in_take;
    logic message_kind;
    logic out_valid;

    assign proc       = r_in_valid && (!out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !proc;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (proc) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    fwr_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_message_kind (message_kind)
    );

    fwr_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_proc         (proc),
        .i_item         (r_in),
        .i_message_kind (message_kind),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (out_valid),
        .o_out_data     (o_out_data)
    );

    assign o_out_valid = out_valid;

endmodule

`default_nettype wire

@@ rtl/core/fwr_apb_regs.sv @@
// ----------------------------------------------------------------------------
// fwr_apb_regs
// apb register file holding the message kind
// ----------------------------------------------------------------------------
`default_nettype none

module fwr_apb_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fwr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [fwr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [fwr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic                                 o_message_kind
);
    import fwr_pkg::*;

    logic r_kind;
    logic n_kind;
    logic wr_en;

    // single register, byte lanes within the word ignored
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        n_kind = r_kind;
        if (wr_en) begin
            n_kind = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_DATA;
        end else begin
            r_kind <= n_kind;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == '0 || paddr != '0) begin
            prdata[0] = r_kind;
        end
    end

    assign pready         = 1'b1;
    assign o_message_kind = r_kind;

endmodule

`default_nettype wire

@@ rtl/core/fwr_core.sv @@
// ----------------------------------------------------------------------------
// fwr_core
// header check, word packing, crc update and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fwr_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_proc,
    input  wire fwr_pkg::t_in  i_item,
    input  wire logic          i_message_kind,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output fwr_pkg::t_out      o_out_data
);
    import fwr_pkg::*;

    logic [3:0]  r_words;
    logic        r_dmg;
    logic        r_prev_dmg;
    logic [15:0] r_crc;
    logic        r_out_valid;
    t_out        r_out;

    logic [3:0]  n_words;
    logic        n_dmg;
    logic        n_prev_dmg;
    logic [15:0] n_crc;
    logic        n_out_valid;
    t_out        n_out;

    logic [3:0]  total;
    logic [3:0]  hdr_lead;
    logic [3:0]  hdr_body;
    logic [3:0]  hdr_tail;
    logic [3:0]  hdr;
    logic [15:0] w;
    logic [3:0]  words_p1;
    logic [15:0] crc_last;
    logic        complete;

    always_comb begin
        total    = (i_message_kind == KIND_RESP) ? WORDS_RESP : WORDS_DATA;
        hdr_lead = (i_message_kind == KIND_RESP) ? HDR_RESP_LEAD : HDR_DATA_LEAD;
        hdr_body = (i_message_kind == KIND_RESP) ? HDR_RESP_BODY : HDR_DATA_BODY;
        hdr_tail = (i_message_kind == KIND_RESP) ? HDR_RESP_TAIL : HDR_DATA_TAIL;
        hdr      = i_item.byte_first[7:4];
        w        = {i_item.byte_third[5:0] & PAYLOAD_MASK,
                    i_item.byte_second[5:0] & PAYLOAD_MASK,
                    i_item.byte_first[3:0]};
        words_p1 = r_words + 4'd1;
        crc_last = r_crc ^ w;
    end

    always_comb begin
        n_words    = r_words;
        n_dmg      = r_dmg;
        n_prev_dmg = r_prev_dmg;
        n_crc      = r_crc;
        n_out      = '0;
        case (t_req'(i_item.req_type))
            REQ_FRAME: begin
                if (r_words == 4'd0 && hdr != hdr_lead && r_prev_dmg) begin
                    n_out.frame_dropped = 1'b1;
                end else begin
                    if (r_words == 4'd0) begin
                        if (hdr != hdr_lead) n_dmg = 1'b1;
                    end else if (words_p1 < total) begin
                        if (hdr != hdr_body) n_dmg = 1'b1;
                    end else if (words_p1 == total) begin
                        if (hdr != hdr_tail) n_dmg = 1'b1;
                    end
                    if (r_words < total) begin
                        n_out.word       = w;
                        n_out.word_index = r_words;
                        n_out.word_valid = 1'b1;
                        if (words_p1 < total) begin
                            n_crc = crc_next(r_crc, w);
                        end else begin
                            n_crc = crc_last;
                            if (crc_last != 16'd0) n_dmg = 1'b1;
                        end
                        n_words = words_p1;
                    end else begin
                        n_dmg = 1'b1;
                    end
                end
            end
            REQ_START: begin
                n_prev_dmg = r_dmg;
                n_dmg      = 1'b0;
                n_words    = 4'd0;
                n_crc      = CRC_INIT;
            end
            REQ_TIMEOUT: begin
                n_dmg = 1'b1;
            end
            default: begin
            end
        endcase
        complete               = (n_words == total);
        n_out.message_complete = complete;
        n_out.crc_ok           = complete && (n_crc == 16'd0);
        n_out.damaged          = n_dmg;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_proc) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words     <= 4'd0;
            r_dmg       <= 1'b0;
            r_prev_dmg  <= 1'b0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_proc) begin
                r_words    <= n_words;
                r_dmg      <= n_dmg;
                r_prev_dmg <= n_prev_dmg;
                r_crc      <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_proc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `AST_HOLDS(a_start_clears, i_clk, i_rst_n, (i_proc && i_item.req_type == REQ_START) |=> (r_words == 4'd0 && r_crc == CRC_INIT && !r_dmg))
    `AST_HOLDS(a_timeout_marks, i_clk, i_rst_n, (i_proc && i_item.req_type == REQ_TIMEOUT) |=> (r_dmg && r_out.damaged))
    `AST_HOLDS(a_result_follows, i_clk, i_rst_n, i_proc |=> r_out_valid)
    `AST_NEVER(a_count_bound, i_clk, i_rst_n, r_words > WORDS_DATA)

endmodule

`default_nettype wire
